// ===== design/srst_pkg.sv =====
// ============================================================================
// srst_pkg: shared types and constants for the replay sequence table
// Holds the word structs, the status and operation codes and the cell record.
// ============================================================================
package srst_pkg;

  localparam int unsigned Entries = 64;
  localparam int unsigned IdxW = $clog2(Entries);
  localparam int unsigned CntW = $clog2(Entries + 1);

  typedef enum logic [1:0] {
    OP_ADMIT   = 2'd0,
    OP_ANCHOR  = 2'd1,
    OP_CONFIRM = 2'd2,
    OP_QUERY   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_MALFORMED    = 3'd1,
    ST_DUPLICATE    = 3'd2,
    ST_GAP          = 3'd3,
    ST_FULL         = 3'd4,
    ST_UNKNOWN      = 3'd5,
    ST_NOT_RECEIVED = 3'd6
  } status_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] issuer_word_0;
    logic [63:0] issuer_word_1;
    logic [63:0] issuer_word_2;
    logic [63:0] issuer_word_3;
    logic [31:0] stream_id;
    logic [63:0] seq;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] next_seq;
    logic [63:0] pending_count;
  } out_word_t;

  // Match result that travels down the chain: the last matching cell wins.
  typedef struct packed {
    logic            hit;
    logic [IdxW-1:0] idx;
    logic [63:0]     received;
    logic [63:0]     applied;
  } match_t;

  // Write command broadcast to all cells at the end of an item.
  typedef struct packed {
    logic            en;
    logic            create;
    logic [IdxW-1:0] idx;
    logic            wr_rcv;
    logic            wr_app;
    logic [63:0]     value_rcv;
    logic [63:0]     value_app;
  } upd_t;

endpackage

// ===== design/stream_replay_sequence_table.sv =====
// ============================================================================
// stream_replay_sequence_table: per-stream anti-replay sequence table
// Tracks (issuer key, stream) pairs in a chain of cells and answers admit,
// anchor, confirm and query words with a status and the pair's counters.
// ============================================================================
//
//   channel | direction | payload     | handshake
//   in      | into      | in_word_t   | in_valid_i / in_stall_o
//   out     | out of    | out_word_t  | out_valid_o / out_stall_i
//
// The chain of cells is walked one group of eight cells per cycle. A carry
// register links the groups, and the last matching cell wins. The update is
// decided and written to one cell in the last group cycle. The next word can
// be taken in the cycle that the result appears, unless the output stalls;
// no word is accepted while the previous one is still being walked.
// Reset clears only the fill count, the group step, the carry register and
// the control flags. A result waiting on a stalled output holds off the next
// word until that result leaves.
module stream_replay_sequence_table (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  srst_pkg::in_word_t    in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output srst_pkg::out_word_t   out_word_o
);

  localparam int unsigned Group = 8;
  localparam int unsigned Groups = (srst_pkg::Entries + Group - 1) / Group;
  localparam int unsigned StepW = $clog2(Groups + 1);

  srst_pkg::in_word_t             item_q;
  logic                           busy_q;
  logic [StepW-1:0]               step_q;
  logic [srst_pkg::CntW-1:0]      used_q;
  srst_pkg::match_t               carry_q;
  srst_pkg::match_t               chain [srst_pkg::Entries+1];
  srst_pkg::upd_t                 upd;
  logic                           out_valid_q;
  srst_pkg::out_word_t            out_q;
  logic                           done;
  srst_pkg::match_t               final_m;
  srst_pkg::status_e              st;
  logic [63:0]                    rcv_n, app_n;
  logic                           hit_n;

  // Only the cells of the current group join the chain in a given cycle;
  // the carry register links consecutive groups.
  assign chain[0] = carry_q;

  for (genvar i = 0; i < srst_pkg::Entries; i++) begin : g_cell
    logic in_grp;
    srst_pkg::match_t m_in;
    assign in_grp = (i / Group) == int'(step_q);
    assign m_in = chain[i];
    srst_cell u_cell (
      .clk_i    (clk_i),
      .my_idx_i (srst_pkg::IdxW'(i)),
      .used_i   (in_grp && (srst_pkg::CntW'(i) < used_q)),
      .item_i   (item_q),
      .upd_i    (upd),
      .match_i  (m_in),
      .match_o  (chain[i+1])
    );
  end

  assign final_m = chain[srst_pkg::Entries];
  assign done = busy_q && (step_q == StepW'(Groups - 1));

  // Decision on the last group's cycle.
  always_comb begin
    st = srst_pkg::ST_OK;
    hit_n = final_m.hit;
    rcv_n = final_m.received;
    app_n = final_m.applied;
    upd = '0;
    upd.idx = final_m.idx;
    unique case (srst_pkg::op_e'(item_q.op))
      srst_pkg::OP_ADMIT: begin
        if (item_q.seq == 64'd0) st = srst_pkg::ST_MALFORMED;
        else if (!final_m.hit) st = srst_pkg::ST_UNKNOWN;
        else if (item_q.seq <= final_m.received) st = srst_pkg::ST_DUPLICATE;
        else if (item_q.seq - final_m.received > 64'd1) st = srst_pkg::ST_GAP;
        else begin
          rcv_n = item_q.seq;
          upd.wr_rcv = 1'b1;
        end
      end
      srst_pkg::OP_ANCHOR: begin
        if (!final_m.hit) begin
          if (used_q >= srst_pkg::CntW'(srst_pkg::Entries)) st = srst_pkg::ST_FULL;
          else begin
            hit_n = 1'b1;
            rcv_n = item_q.seq;
            app_n = '0;
            upd.create = 1'b1;
            upd.wr_rcv = 1'b1;
            upd.wr_app = 1'b1;
            upd.idx = used_q[srst_pkg::IdxW-1:0];
          end
        end else if (item_q.seq <= final_m.received) st = srst_pkg::ST_DUPLICATE;
        else begin
          rcv_n = item_q.seq;
          upd.wr_rcv = 1'b1;
        end
      end
      srst_pkg::OP_CONFIRM: begin
        if (!final_m.hit) st = srst_pkg::ST_UNKNOWN;
        else if (item_q.seq > final_m.received) st = srst_pkg::ST_NOT_RECEIVED;
        else if (item_q.seq <= final_m.applied) st = srst_pkg::ST_DUPLICATE;
        else begin
          app_n = item_q.seq;
          upd.wr_app = 1'b1;
        end
      end
      default: begin
        if (!final_m.hit) st = srst_pkg::ST_UNKNOWN;
      end
    endcase
    upd.value_rcv = rcv_n;
    upd.value_app = app_n;
    upd.en = done && (upd.wr_rcv || upd.wr_app);
  end

  // A new word is taken once the previous result has left or is leaving.
  assign in_stall_o = busy_q || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
      carry_q     <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (in_valid_i && !in_stall_o) begin
        busy_q  <= 1'b1;
        step_q  <= '0;
        carry_q <= '0;
      end else if (done) begin
        busy_q      <= 1'b0;
        out_valid_q <= 1'b1;
        if (upd.create) used_q <= used_q + srst_pkg::CntW'(1);
      end else if (busy_q) begin
        step_q  <= step_q + StepW'(1);
        carry_q <= final_m;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) item_q <= in_word_i;
    if (done) begin
      out_q.status        <= st;
      out_q.next_seq      <= !hit_n ? 64'd1 : ((&rcv_n) ? rcv_n : rcv_n + 64'd1);
      out_q.pending_count <= !hit_n ? 64'd0 : rcv_n - app_n;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= srst_pkg::CntW'(srst_pkg::Entries))
    else $error("fill count above table size");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> in_stall_o)
    else $error("word accepted while busy");
  a_done_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> out_valid_o)
    else $error("finished word gave no result");
`endif

endmodule

// ===== design/srst_cell.sv =====
// ============================================================================
// srst_cell: one table entry
// Stores a key, a stream and two sequences, compares the key and stream
// against the broadcast item and passes the match record on to its neighbor.
// ============================================================================
module srst_cell (
  input  logic                          clk_i,
  input  logic [srst_pkg::IdxW-1:0]     my_idx_i,
  input  logic                          used_i,
  input  srst_pkg::in_word_t            item_i,
  input  srst_pkg::upd_t                upd_i,
  input  srst_pkg::match_t              match_i,
  output srst_pkg::match_t              match_o
);

  logic [255:0] key_q;
  logic [31:0]  stream_q;
  logic [63:0]  rcv_q;
  logic [63:0]  app_q;
  logic         same;

  assign same = used_i && (stream_q == item_i.stream_id) &&
                (key_q == {item_i.issuer_word_3, item_i.issuer_word_2,
                           item_i.issuer_word_1, item_i.issuer_word_0});

  always_comb begin
    match_o = match_i;
    if (same) begin
      match_o.hit      = 1'b1;
      match_o.idx      = my_idx_i;
      match_o.received = rcv_q;
      match_o.applied  = app_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.en && upd_i.idx == my_idx_i) begin
      if (upd_i.create) begin
        key_q    <= {item_i.issuer_word_3, item_i.issuer_word_2,
                     item_i.issuer_word_1, item_i.issuer_word_0};
        stream_q <= item_i.stream_id;
      end
      if (upd_i.wr_rcv) rcv_q <= upd_i.value_rcv;
      if (upd_i.wr_app) app_q <= upd_i.value_app;
    end
  end

endmodule

// ===== tb/tb_stream_replay_sequence_table_chk.sv =====
// ============================================================================
// tb_stream_replay_sequence_table_chk: scoreboard for the replay sequence table
// Watches both channels, keeps its own copy of the pair table, predicts the
// status and counters of every accepted word and compares them in order.
// ============================================================================
module tb_stream_replay_sequence_table_chk
  import srst_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  in_word_t    in_word_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  out_word_t   out_word_i,
  output int          err_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [255:0] pair_key [Entries];
  logic [31:0]  pair_stream [Entries];
  logic [63:0]  pair_rcv [Entries];
  logic [63:0]  pair_app [Entries];
  int unsigned  pairs_used;
  out_word_t    sequence_results [$];

  assign pending_o = sequence_results.size();

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $time);
    err_count_o++;
  endtask

  function automatic out_word_t predict_sequence(input in_word_t w);
    out_word_t    r;
    logic [255:0] k;
    int           e;
    status_e      st;
    k  = {w.issuer_word_0, w.issuer_word_1, w.issuer_word_2, w.issuer_word_3};
    e  = -1;
    st = ST_OK;
    for (int i = 0; i < pairs_used; i++)
      if (pair_key[i] == k && pair_stream[i] == w.stream_id) e = i;
    case (op_e'(w.op))
      OP_ADMIT: begin
        if (w.seq == 0) st = ST_MALFORMED;
        else if (e < 0) st = ST_UNKNOWN;
        else if (w.seq <= pair_rcv[e]) st = ST_DUPLICATE;
        else if (w.seq - pair_rcv[e] > 1) st = ST_GAP;
        else pair_rcv[e] = w.seq;
      end
      OP_ANCHOR: begin
        if (e < 0) begin
          if (pairs_used >= Entries) st = ST_FULL;
          else begin
            e = pairs_used;
            pairs_used++;
            pair_key[e]    = k;
            pair_stream[e] = w.stream_id;
            pair_rcv[e]    = w.seq;
            pair_app[e]    = '0;
          end
        end else if (w.seq <= pair_rcv[e]) st = ST_DUPLICATE;
        else pair_rcv[e] = w.seq;
      end
      OP_CONFIRM: begin
        if (e < 0) st = ST_UNKNOWN;
        else if (w.seq > pair_rcv[e]) st = ST_NOT_RECEIVED;
        else if (w.seq <= pair_app[e]) st = ST_DUPLICATE;
        else pair_app[e] = w.seq;
      end
      default: begin
        if (e < 0) st = ST_UNKNOWN;
      end
    endcase
    r.status = st;
    if (e < 0) begin
      r.next_seq      = 64'd1;
      r.pending_count = '0;
    end else begin
      r.next_seq      = (&pair_rcv[e]) ? pair_rcv[e] : pair_rcv[e] + 1;
      r.pending_count = pair_rcv[e] - pair_app[e];
    end
    return r;
  endfunction

  initial begin
    err_count_o = 0;
    pairs_used  = 0;
  end

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) sequence_results.push_back(predict_sequence(in_word_i));
      if (out_valid_i && !out_stall_i) begin
        if (sequence_results.size() == 0) begin
          report_mismatch("unexpected word", out_word_i.next_seq, '0);
        end else begin
          want = sequence_results.pop_front();
          if (out_word_i.status !== want.status)
            report_mismatch("status", out_word_i.status, want.status);
          if (out_word_i.next_seq !== want.next_seq)
            report_mismatch("next_seq", out_word_i.next_seq, want.next_seq);
          if (out_word_i.pending_count !== want.pending_count)
            report_mismatch("pending_count", out_word_i.pending_count,
                            want.pending_count);
        end
      end
    end
  end
endmodule

// ===== tb/tb_stream_replay_sequence_table.sv =====
// ============================================================================
// tb_stream_replay_sequence_table: top of the replay sequence table bench
// Drives directed and random words with random gaps and output stalls, and
// gives the verdict from the checker's error count.
// ============================================================================
module tb_stream_replay_sequence_table;
  import srst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 20000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;
  int        err_count;
  int        pending;
  int        idle_cycles = 0;
  int        sent_count = 0;
  bit        no_idle = 1'b0;
  bit        hold_off = 1'b0;

  // A small pool of pairs, so that random words mostly hit tracked entries.
  logic [255:0] pool_key [16];
  logic [31:0]  pool_stream [16];
  logic [63:0]  pool_seq [16];

  always #1 clk = ~clk;

  stream_replay_sequence_table dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  tb_stream_replay_sequence_table_chk chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_word_i  (out_word),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Sends one word and holds it until the block takes it. The valid stays
  // high afterwards unless the next call idles first.
  task automatic send_word(input op_e op, input logic [255:0] k,
                           input logic [31:0] s, input logic [63:0] q);
    in_word_t w;
    w.op            = op;
    w.issuer_word_0 = k[255:192];
    w.issuer_word_1 = k[191:128];
    w.issuer_word_2 = k[127:64];
    w.issuer_word_3 = k[63:0];
    w.stream_id     = s;
    w.seq           = q;
    while (!no_idle && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  // The receiver stalls at random, except while the fast stretch runs, and
  // once holds off for a long stretch so the table backs up into its input.
  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (no_idle) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 35);
  end

  // Long hold-off of the receiver, timed in cycles on its own.
  initial begin
    wait (sent_count >= 500);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (200) @(posedge clk);
    hold_off = 1'b0;
  end

  // Watchdog: counts cycles in which neither channel moves a word.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchdogLimit) begin
      $display("tb_stream_replay_sequence_table: done, errors");
      $finish;
    end
  end

  initial begin
    logic [255:0] k;
    int           p;
    int           r;
    logic [63:0]  q;
    for (int i = 0; i < 16; i++) begin
      pool_key[i]    = {rand64(), rand64(), rand64(), rand64()};
      pool_stream[i] = (i < 8) ? $urandom() : pool_stream[0] + i;
      if (i >= 8) pool_key[i] = pool_key[0];
      pool_seq[i]    = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: every status but full, and the field extremes.
    k = pool_key[0];
    send_word(OP_QUERY, k, pool_stream[0], '0);             // unknown pair
    send_word(OP_ADMIT, k, pool_stream[0], 64'd5);          // admit unknown
    send_word(OP_ADMIT, k, pool_stream[0], '0);             // zero is malformed
    send_word(OP_CONFIRM, k, pool_stream[0], 64'd1);        // confirm unknown
    send_word(OP_ANCHOR, k, pool_stream[0], '0);            // anchor at zero
    send_word(OP_ANCHOR, k, pool_stream[0], '0);            // anchor duplicate
    send_word(OP_ADMIT, k, pool_stream[0], 64'd1);          // in order
    send_word(OP_ADMIT, k, pool_stream[0], 64'd1);          // duplicate
    send_word(OP_ADMIT, k, pool_stream[0], 64'd3);          // gap
    send_word(OP_CONFIRM, k, pool_stream[0], 64'd9);        // not received
    send_word(OP_CONFIRM, k, pool_stream[0], 64'd1);        // applied moves up
    send_word(OP_CONFIRM, k, pool_stream[0], 64'd1);        // confirm duplicate
    send_word(OP_ANCHOR, '1, '1, '1 - 1);                   // all-ones key/stream
    send_word(OP_ADMIT, '1, '1, '1);                        // reaches all ones
    send_word(OP_QUERY, '1, '1, '0);                        // next_seq saturates
    send_word(OP_CONFIRM, '1, '1, '1);
    send_word(OP_ANCHOR, '0, '0, '1);
    send_word(OP_ADMIT, '0, '0, '1);

    // Random part. The first pool pair is anchored above; the rest come from
    // the pool, with some anchors of fresh random pairs until the table fills.
    for (int n = 0; n < 1100; n++) begin
      sent_count = n;
      no_idle  = (n >= 300 && n < 450);
      p = $urandom_range(15);
      r = $urandom_range(99);
      if (r < 8) begin
        send_word(OP_ANCHOR, {rand64(), rand64(), rand64(), rand64()}, $urandom(),
                  rand64());
      end else if (r < 55) begin
        // Mostly in order, sometimes off by a little.
        q = pool_seq[p] + 1 - $urandom_range(1) + ($urandom_range(9) == 0 ? 2 : 0);
        if (q == pool_seq[p] + 1) pool_seq[p] = q;
        send_word(OP_ADMIT, pool_key[p], pool_stream[p], q);
      end else if (r < 65) begin
        q = pool_seq[p] + $urandom_range(3);
        if (q > pool_seq[p]) pool_seq[p] = q;
        send_word(OP_ANCHOR, pool_key[p], pool_stream[p], q);
      end else if (r < 85) begin
        send_word(OP_CONFIRM, pool_key[p], pool_stream[p],
                  pool_seq[p] - $urandom_range(2) + $urandom_range(1));
      end else if (r < 92) begin
        send_word(OP_QUERY, pool_key[p], pool_stream[p], rand64());
      end else begin
        send_word(op_e'($urandom_range(3)), {rand64(), rand64(), rand64(), rand64()},
                  $urandom(), rand64());
      end
    end
    in_valid <= 1'b0;
    no_idle  = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_stream_replay_sequence_table: done, clean");
    end else begin
      $display("tb_stream_replay_sequence_table: done, errors");
    end
    $finish;
  end
endmodule
